// File: hw/rtl/gbfs_pkg.sv
// ----------------------------------------------------------------------------
// Grid BFS package
// Command, cell code, phase, read-state, register and direction constants shared by the search core.
// ----------------------------------------------------------------------------
package gbfs_pkg;

	typedef enum logic [2:0] {
		CMD_SET    = 3'd0,
		CMD_ERASE  = 3'd1,
		CMD_TOGGLE = 3'd2,
		CMD_READ   = 3'd3,
		CMD_START  = 3'd4,
		CMD_STEP   = 3'd5,
		CMD_CLEAR  = 3'd6,
		CMD_NOP    = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		CODE_EMPTY   = 2'd0,
		CODE_WALL    = 2'd1,
		CODE_VISITED = 2'd2,
		CODE_PATH    = 2'd3
	} code_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_RUN    = 2'd1,
		PH_FOUND  = 2'd2,
		PH_NOPATH = 2'd3
	} phase_t;

	localparam logic [2:0] RD_EMPTY   = 3'd0;
	localparam logic [2:0] RD_WALL    = 3'd1;
	localparam logic [2:0] RD_START   = 3'd2;
	localparam logic [2:0] RD_END     = 3'd3;
	localparam logic [2:0] RD_VISITED = 3'd4;
	localparam logic [2:0] RD_PATH    = 3'd5;

	localparam logic [2:0] REG_ROWS = 3'd0;
	localparam logic [2:0] REG_COLS = 3'd1;
	localparam logic [2:0] REG_SROW = 3'd2;
	localparam logic [2:0] REG_SCOL = 3'd3;
	localparam logic [2:0] REG_EROW = 3'd4;
	localparam logic [2:0] REG_ECOL = 3'd5;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

endpackage

// File: hw/rtl/gbfs_cell_mem.sv
// ----------------------------------------------------------------------------
// Grid BFS cell memory
// Per-cell word of cell code, discovered mark and parent direction, one write port and one read port.
// ----------------------------------------------------------------------------
module gbfs_cell_mem #(
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [4:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [4:0]    rdata
);

	logic [4:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/gbfs_fifo_mem.sv
// ----------------------------------------------------------------------------
// Grid BFS frontier memory
// Queue storage of cell indexes, written at the tail and read at the head.
// ----------------------------------------------------------------------------
module gbfs_fifo_mem #(
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [AW-1:0] rdata
);

	logic [AW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/grid_bfs_path_search_core.sv
// ----------------------------------------------------------------------------
// Grid BFS path search core
// Edits a grid of cell codes and runs a 4-connected breadth-first search.
// A step pops one cell and queues its undiscovered neighbours; when it pops the end
// cell it marks the path back to the start instead. Start and clear sweep the whole
// cell memory. After reset a clearing pass runs before the first transaction.
// ----------------------------------------------------------------------------
module grid_bfs_path_search_core
	import gbfs_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] command,
	input  logic [5:0] cell_row,
	input  logic [5:0] cell_col,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] cell_state,
	output logic [1:0] search_status,
	output logic       popped_valid,
	output logic [5:0] popped_row,
	output logic [5:0] popped_col
);

	localparam int RB = $clog2(MAX_ROWS);
	localparam int CB = $clog2(MAX_COLS);
	localparam int AW = RB + CB;
	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int DEPTH = 2 ** AW;
	localparam logic [AW:0] SWEEP_FILL = (AW+1)'(DEPTH);
	localparam logic [AW:0] SWEEP_LAST = (AW+1)'(DEPTH + 2);

	typedef enum logic [10:0] {
		S_SWEEP = 11'b00000000001,
		S_IDLE  = 11'b00000000010,
		S_ERD   = 11'b00000000100,
		S_EWR   = 11'b00000001000,
		S_PRD   = 11'b00000010000,
		S_PCHK  = 11'b00000100000,
		S_NRD   = 11'b00001000000,
		S_NWR   = 11'b00010000000,
		S_MRD   = 11'b00100000000,
		S_MWR   = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [6:0] rows_q, cols_q;
	logic [5:0] srow_q, scol_q, erow_q, ecol_q;
	phase_t     phase_q;
	logic [AW:0] head_q, tail_q;
	logic [AW:0] sweep_q;
	logic        sweep_start_q;

	logic [2:0] cmd_q;
	logic [5:0] row_q, col_q;
	logic [8:0] cur_r_q, cur_c_q;
	logic [1:0] dir_q;
	logic [AW:0] walk_q;

	logic [2:0] res_state_q;
	logic       res_pv_q;
	logic [5:0] res_pr_q, res_pc_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [4:0]    mem_wdata, mem_rdata;
	logic          fq_we;
	logic [AW-1:0] fq_wdata, fq_rdata;

	gbfs_cell_mem #(.AW(AW)) u_cell (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	gbfs_fifo_mem #(.AW(AW)) u_fifo (
		.clk(clk), .we(fq_we), .waddr(tail_q[AW-1:0]), .wdata(fq_wdata),
		.raddr(head_q[AW-1:0]), .rdata(fq_rdata)
	);

	logic [8:0] eff_rows, eff_cols;
	assign eff_rows = ({2'b0, rows_q} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : {2'b0, rows_q};
	assign eff_cols = ({2'b0, cols_q} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {2'b0, cols_q};

	function automatic logic [AW-1:0] idx(input logic [8:0] r, input logic [8:0] c);
		idx = {r[RB-1:0], c[CB-1:0]};
	endfunction

	// Input cell checks.
	logic in_ok, in_special;
	assign in_ok = ({3'b0, row_q} < eff_rows) && ({3'b0, col_q} < eff_cols);
	assign in_special = (row_q == srow_q && col_q == scol_q) ||
		(row_q == erow_q && col_q == ecol_q);

	// Neighbour of the current cell in direction dir_q.
	logic [8:0] nb_r, nb_c;
	always_comb begin
		nb_r = cur_r_q;
		nb_c = cur_c_q;
		unique case (dir_q)
			DIR_UP:    nb_r = cur_r_q - 9'd1;
			DIR_DOWN:  nb_r = cur_r_q + 9'd1;
			DIR_LEFT:  nb_c = cur_c_q - 9'd1;
			default:   nb_c = cur_c_q + 9'd1;
		endcase
	end
	logic nb_ok, nb_special;
	assign nb_ok = (nb_r < eff_rows) && (nb_c < eff_cols);
	assign nb_special = (nb_r == {3'b0, srow_q} && nb_c == {3'b0, scol_q}) ||
		(nb_r == {3'b0, erow_q} && nb_c == {3'b0, ecol_q});

	logic cur_start, cur_end, cur_in_store;
	assign cur_start = cur_r_q == {3'b0, srow_q} && cur_c_q == {3'b0, scol_q};
	assign cur_end = cur_r_q == {3'b0, erow_q} && cur_c_q == {3'b0, ecol_q};
	assign cur_in_store = cur_r_q < 9'(MAX_ROWS) && cur_c_q < 9'(MAX_COLS);

	logic start_in;
	assign start_in = ({3'b0, srow_q} < eff_rows) && ({3'b0, scol_q} < eff_cols);

	logic [RB-1:0] pop_r;
	logic [CB-1:0] pop_c;
	assign pop_r = fq_rdata[AW-1:CB];
	assign pop_c = fq_rdata[CB-1:0];

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign cell_state = res_state_q;
	assign search_status = phase_q;
	assign popped_valid = res_pv_q;
	assign popped_row = res_pr_q;
	assign popped_col = res_pc_q;

	// Memory port control.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = idx(cur_r_q, cur_c_q);
		mem_wdata = mem_rdata;
		mem_raddr = idx(cur_r_q, cur_c_q);
		fq_we = 1'b0;
		fq_wdata = idx(nb_r, nb_c);
		unique case (state_q)
			S_SWEEP: begin
				mem_raddr = sweep_q[AW-1:0];
				mem_waddr = sweep_q[AW-1:0] - AW'(1);
				mem_wdata = {3'b000, (mem_rdata[1:0] == CODE_WALL) ? CODE_WALL : CODE_EMPTY};
				if (sweep_start_q) begin
					mem_we = 1'b1;
					mem_waddr = sweep_q[AW-1:0];
					mem_wdata = 5'b0;
				end else if (sweep_q > SWEEP_FILL) begin
					// On start, if the start cell is inside the grid, it is marked discovered and queued; its code is kept.
					mem_raddr = idx({3'b0, srow_q}, {3'b0, scol_q});
					mem_waddr = idx({3'b0, srow_q}, {3'b0, scol_q});
					mem_wdata = {2'b00, 1'b1, mem_rdata[1:0]};
					mem_we = (sweep_q == SWEEP_LAST) && cmd_q == CMD_START && start_in;
					fq_we = mem_we;
					fq_wdata = idx({3'b0, srow_q}, {3'b0, scol_q});
				end else begin
					mem_we = (sweep_q != '0);
				end
			end
			S_ERD: mem_raddr = idx({3'b0, row_q}, {3'b0, col_q});
			S_EWR: begin
				mem_waddr = idx({3'b0, row_q}, {3'b0, col_q});
				mem_we = in_ok && !in_special && cmd_q != CMD_READ;
				mem_wdata = mem_rdata;
				case (cmd_q)
					CMD_SET:   mem_wdata[1:0] = CODE_WALL;
					CMD_ERASE: mem_wdata[1:0] = CODE_EMPTY;
					default:   mem_wdata[1:0] =
						(mem_rdata[1:0] == CODE_WALL) ? CODE_EMPTY : CODE_WALL;
				endcase
			end
			S_NRD: mem_raddr = idx(nb_r, nb_c);
			S_NWR: begin
				mem_waddr = idx(nb_r, nb_c);
				if (nb_ok && !mem_rdata[2] &&
					(nb_special || mem_rdata[1:0] != CODE_WALL)) begin
					mem_we = 1'b1;
					fq_we = 1'b1;
					mem_wdata = {dir_q, 1'b1,
						(!nb_special && mem_rdata[1:0] == CODE_EMPTY) ?
						CODE_VISITED : mem_rdata[1:0]};
				end
			end
			S_MWR: begin
				mem_we = !cur_start && !cur_end &&
					(mem_rdata[1:0] == CODE_EMPTY || mem_rdata[1:0] == CODE_VISITED);
				mem_wdata = {mem_rdata[4:2], CODE_PATH};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd64;
			cols_q <= 7'd64;
			srow_q <= 6'd5;
			scol_q <= 6'd5;
			erow_q <= 6'd24;
			ecol_q <= 6'd34;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS: rows_q <= cfg_data;
				REG_COLS: cols_q <= cfg_data;
				REG_SROW: srow_q <= cfg_data[5:0];
				REG_SCOL: scol_q <= cfg_data[5:0];
				REG_EROW: erow_q <= cfg_data[5:0];
				REG_ECOL: ecol_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			phase_q <= PH_IDLE;
			head_q <= '0;
			tail_q <= '0;
			sweep_q <= '0;
			sweep_start_q <= 1'b1;
			cmd_q <= CMD_NOP;
		end else begin
			unique case (state_q)
				S_SWEEP: begin
					// Reset clears all entries; start and clear keep only walls.
					if (sweep_start_q) begin
						if (sweep_q == SWEEP_FILL - 1'b1) begin
							sweep_start_q <= 1'b0;
							sweep_q <= '0;
							state_q <= S_IDLE;
						end else begin
							sweep_q <= sweep_q + 1'b1;
						end
					end else if (sweep_q == SWEEP_LAST) begin
						head_q <= '0;
						tail_q <= (cmd_q == CMD_START && start_in) ? (AW+1)'(1) : '0;
						sweep_q <= '0;
						state_q <= S_OUT;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= command;
						row_q <= cell_row;
						col_q <= cell_col;
						res_state_q <= RD_EMPTY;
						res_pv_q <= 1'b0;
						res_pr_q <= '0;
						res_pc_q <= '0;
						unique case (cmd_t'(command))
							CMD_SET, CMD_ERASE, CMD_TOGGLE, CMD_READ: state_q <= S_ERD;
							CMD_START: begin
								phase_q <= PH_RUN;
								head_q <= '0;
								tail_q <= '0;
								sweep_q <= '0;
								state_q <= S_SWEEP;
							end
							CMD_CLEAR: begin
								phase_q <= PH_IDLE;
								head_q <= '0;
								tail_q <= '0;
								sweep_q <= '0;
								state_q <= S_SWEEP;
							end
							CMD_STEP: begin
								if (phase_q == PH_IDLE) begin
									phase_q <= PH_NOPATH;
									state_q <= S_OUT;
								end else if (phase_q != PH_RUN) begin
									state_q <= S_OUT;
								end else if (head_q == tail_q) begin
									phase_q <= PH_NOPATH;
									state_q <= S_OUT;
								end else begin
									state_q <= S_PRD;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_ERD: state_q <= S_EWR;
				S_EWR: begin
					if (cmd_q == CMD_READ && in_ok) begin
						if (in_special && row_q == srow_q && col_q == scol_q) begin
							res_state_q <= RD_START;
						end else if (in_special) begin
							res_state_q <= RD_END;
						end else begin
							case (code_t'(mem_rdata[1:0]))
								CODE_WALL:    res_state_q <= RD_WALL;
								CODE_VISITED: res_state_q <= RD_VISITED;
								CODE_PATH:    res_state_q <= RD_PATH;
								default:      res_state_q <= RD_EMPTY;
							endcase
						end
					end
					state_q <= S_OUT;
				end
				S_PRD: begin
					head_q <= head_q + 1'b1;
					state_q <= S_PCHK;
				end
				S_PCHK: begin
					cur_r_q <= {{(9-RB){1'b0}}, pop_r};
					cur_c_q <= {{(9-CB){1'b0}}, pop_c};
					res_pv_q <= 1'b1;
					res_pr_q <= 6'(pop_r);
					res_pc_q <= 6'(pop_c);
					dir_q <= DIR_UP;
					walk_q <= '0;
					if ({{(9-RB){1'b0}}, pop_r} == {3'b0, erow_q} &&
						{{(9-CB){1'b0}}, pop_c} == {3'b0, ecol_q}) begin
						phase_q <= PH_FOUND;
						cur_r_q <= {3'b0, erow_q};
						cur_c_q <= {3'b0, ecol_q};
						state_q <= S_MRD;
					end else begin
						state_q <= S_NRD;
					end
				end
				S_NRD: state_q <= S_NWR;
				S_NWR: begin
					if (mem_we) begin
						tail_q <= tail_q + 1'b1;
					end
					dir_q <= dir_q + 2'd1;
					state_q <= (dir_q == DIR_RIGHT) ? S_OUT : S_NRD;
				end
				S_MRD: state_q <= cur_in_store ? S_MWR : S_OUT;
				S_MWR: begin
					walk_q <= walk_q + 1'b1;
					if (cur_start || !mem_rdata[2] || walk_q == CELLS[AW:0] - 1'b1) begin
						state_q <= S_OUT;
					end else begin
						unique case (mem_rdata[4:3])
							DIR_UP:   cur_r_q <= cur_r_q + 9'd1;
							DIR_DOWN: cur_r_q <= cur_r_q - 9'd1;
							DIR_LEFT: cur_c_q <= cur_c_q + 9'd1;
							default:  cur_c_q <= cur_c_q - 9'd1;
						endcase
						state_q <= S_MRD;
					end
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: tb/sv/tb_grid_bfs_path_search_core.sv
// ----------------------------------------------------------------------------
// Grid BFS path search core testbench
// Drives wall edits, reads and search commands over a series of grid settings
// and compares every result with a predictor that keeps its own copy of the
// grid, the discovered marks, the parent directions and the frontier queue.
// ----------------------------------------------------------------------------
module tb_grid_bfs_path_search_core;
	import gbfs_pkg::*;

	localparam int NR = 64;
	localparam int NC = 64;
	localparam int NCELLS = NR * NC;
	localparam int WATCHDOG_LIMIT = 60000;

	typedef struct {
		cmd_t       cmd;
		logic [5:0] row;
		logic [5:0] col;
	} grid_op_t;

	typedef struct {
		logic [2:0] state;
		logic [1:0] status;
		logic       pv;
		logic [5:0] prow;
		logic [5:0] pcol;
	} grid_res_t;

	class grid_scoreboard;
		logic [1:0]  codes [NCELLS];
		bit          disc [NCELLS];
		logic [1:0]  parent [NCELLS];
		int          frontier [NCELLS];
		int          head, tail;
		phase_t      phase;
		int          rows, cols, srow, scol, erow, ecol;
		grid_res_t   pending_q [$];
		int          fails;

		function new();
			foreach (codes[i]) begin
				codes[i] = CODE_EMPTY;
				disc[i] = 0;
				parent[i] = DIR_UP;
			end
			head = 0;
			tail = 0;
			phase = PH_IDLE;
			rows = 64; cols = 64; srow = 5; scol = 5; erow = 24; ecol = 34;
			fails = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [6:0] v);
			case (idx)
				REG_ROWS: rows = v;
				REG_COLS: cols = v;
				REG_SROW: srow = v[5:0];
				REG_SCOL: scol = v[5:0];
				REG_EROW: erow = v[5:0];
				REG_ECOL: ecol = v[5:0];
				default: ;
			endcase
		endfunction

		function bit inside_grid(int r, int c);
			int er, ec;
			er = rows > NR ? NR : rows;
			ec = cols > NC ? NC : cols;
			return r >= 0 && c >= 0 && r < er && c < ec;
		endfunction

		function bit at_start(int r, int c);
			return r == srow && c == scol;
		endfunction

		function bit at_end(int r, int c);
			return r == erow && c == ecol;
		endfunction

		function void wipe_search();
			foreach (codes[i]) begin
				if (codes[i] == CODE_VISITED || codes[i] == CODE_PATH)
					codes[i] = CODE_EMPTY;
				disc[i] = 0;
			end
			head = 0;
			tail = 0;
		endfunction

		function void trace_path();
			int r, c, i;
			r = erow;
			c = ecol;
			for (int n = 0; n < NCELLS; n++) begin
				if (r < 0 || c < 0 || r >= NR || c >= NC) return;
				i = r * NC + c;
				if (!at_start(r, c) && !at_end(r, c) &&
				    (codes[i] == CODE_EMPTY || codes[i] == CODE_VISITED))
					codes[i] = CODE_PATH;
				if (at_start(r, c) || !disc[i]) return;
				case (parent[i])
					DIR_UP:    r = r + 1;
					DIR_DOWN:  r = r - 1;
					DIR_LEFT:  c = c + 1;
					default:   c = c - 1;
				endcase
			end
		endfunction

		function void search_step(ref grid_res_t res);
			int idx, r, c, nr, nc, ni;
			bit spec;
			if (phase != PH_RUN) begin
				if (phase == PH_IDLE) phase = PH_NOPATH;
				return;
			end
			if (head == tail) begin
				phase = PH_NOPATH;
				return;
			end
			idx = frontier[head % NCELLS];
			head++;
			r = idx / NC;
			c = idx % NC;
			res.pv = 1;
			res.prow = r;
			res.pcol = c;
			if (at_end(r, c)) begin
				phase = PH_FOUND;
				trace_path();
				return;
			end
			for (int d = 0; d < 4; d++) begin
				nr = r + (d == 0 ? -1 : d == 1 ? 1 : 0);
				nc = c + (d == 2 ? -1 : d == 3 ? 1 : 0);
				if (!inside_grid(nr, nc)) continue;
				ni = nr * NC + nc;
				if (disc[ni]) continue;
				spec = at_start(nr, nc) || at_end(nr, nc);
				if (!spec && codes[ni] == CODE_WALL) continue;
				disc[ni] = 1;
				parent[ni] = d;
				frontier[tail % NCELLS] = ni;
				tail++;
				if (!spec && codes[ni] == CODE_EMPTY) codes[ni] = CODE_VISITED;
			end
		endfunction

		function void note_input(grid_op_t op);
			grid_res_t res;
			int r, c, i;
			bit ok, spec;
			r = op.row;
			c = op.col;
			ok = inside_grid(r, c);
			i = ok ? r * NC + c : 0;
			spec = at_start(r, c) || at_end(r, c);
			res = '{default: '0};
			case (op.cmd)
				CMD_SET: if (ok && !spec) codes[i] = CODE_WALL;
				CMD_ERASE: if (ok && !spec) codes[i] = CODE_EMPTY;
				CMD_TOGGLE: begin
					if (ok && !spec)
						codes[i] = codes[i] == CODE_WALL ? CODE_EMPTY : CODE_WALL;
				end
				CMD_READ: begin
					if (!ok) res.state = RD_EMPTY;
					else if (at_start(r, c)) res.state = RD_START;
					else if (at_end(r, c)) res.state = RD_END;
					else begin
						case (codes[i])
							CODE_EMPTY:   res.state = RD_EMPTY;
							CODE_WALL:    res.state = RD_WALL;
							CODE_VISITED: res.state = RD_VISITED;
							default:      res.state = RD_PATH;
						endcase
					end
				end
				CMD_START: begin
					wipe_search();
					phase = PH_RUN;
					if (inside_grid(srow, scol)) begin
						disc[srow * NC + scol] = 1;
						frontier[0] = srow * NC + scol;
						tail = 1;
					end
				end
				CMD_STEP: search_step(res);
				CMD_CLEAR: begin
					wipe_search();
					phase = PH_IDLE;
				end
				default: ;
			endcase
			res.status = phase;
			pending_q.insert(pending_q.size(), res);
		endfunction

		function void check_result(grid_res_t got);
			grid_res_t exp_r;
			if (pending_q.size() == 0) begin
				$error("result with no expectation waiting");
				fails++;
				return;
			end
			exp_r = pending_q.pop_front();
			if (got.state !== exp_r.state) begin
				$error("cell_state expected %0d actual %0d", exp_r.state, got.state);
				fails++;
			end
			if (got.status !== exp_r.status) begin
				$error("search_status expected %0d actual %0d", exp_r.status, got.status);
				fails++;
			end
			if (got.pv !== exp_r.pv) begin
				$error("popped_valid expected %0d actual %0d", exp_r.pv, got.pv);
				fails++;
			end
			if (got.prow !== exp_r.prow) begin
				$error("popped_row expected %0d actual %0d", exp_r.prow, got.prow);
				fails++;
			end
			if (got.pcol !== exp_r.pcol) begin
				$error("popped_col expected %0d actual %0d", exp_r.pcol, got.pcol);
				fails++;
			end
		endfunction
	endclass

	logic       clk = 0;
	logic       arst_n = 0;
	logic       cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;
	logic       in_valid = 0;
	logic       in_ready;
	logic [2:0] command = CMD_NOP;
	logic [5:0] cell_row = '0;
	logic [5:0] cell_col = '0;
	logic       out_valid;
	logic       out_ready = 0;
	logic [2:0] cell_state;
	logic [1:0] search_status;
	logic       popped_valid;
	logic [5:0] popped_row;
	logic [5:0] popped_col;

	grid_scoreboard sb = new();
	grid_op_t       op_q [$];
	int             op_count = 0;
	bit             calm = 0;
	int             send_gap = 0;
	int             recv_gap = 0;
	int             quiet_cycles = 0;

	grid_bfs_path_search_core u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .cell_row(cell_row), .cell_col(cell_col),
		.out_valid(out_valid), .out_ready(out_ready),
		.cell_state(cell_state), .search_status(search_status),
		.popped_valid(popped_valid), .popped_row(popped_row), .popped_col(popped_col)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		grid_op_t op;
		if (in_valid && in_ready) sb.note_input('{cmd_t'(command), cell_row, cell_col});
		if (in_valid && !in_ready) begin
		end else if (send_gap > 0) begin
			send_gap <= send_gap - 1;
			in_valid <= 0;
		end else if (op_q.size() > 0 && arst_n) begin
			op = op_q.pop_front();
			command <= op.cmd;
			cell_row <= op.row;
			cell_col <= op.col;
			in_valid <= 1;
			if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 14);
		end else begin
			in_valid <= 0;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result('{cell_state, search_status, popped_valid, popped_row, popped_col});
		if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_ready <= 0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			recv_gap <= $urandom_range(0, 13);
			out_ready <= 0;
		end else begin
			out_ready <= 1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic push_op(cmd_t cmd, int r, int c);
		grid_op_t op;
		op = '{cmd, 6'(r), 6'(c)};
		op_q.insert(op_q.size(), op);
		op_count++;
	endtask

	task automatic wait_idle();
		while (op_q.size() > 0 || in_valid || sb.pending_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_grid_regs(int rows, int cols, int sr, int sc, int er, int ec);
		int v [6];
		v = '{rows, cols, sr, sc, er, ec};
		for (int i = 0; i < 6; i++) begin
			@(posedge clk);
			cfg_we <= 1;
			cfg_index <= 3'(i);
			cfg_data <= 7'(v[i]);
			sb.write_reg(3'(i), 7'(v[i]));
		end
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_phase();
		int rows, cols, er, ec, span, nsteps;
		case ($urandom_range(0, 9))
			0: begin rows = 1; cols = $urandom_range(1, 8); end
			1: begin rows = $urandom_range(1, 8); cols = 1; end
			2: begin rows = 64; cols = 64; end
			3: begin rows = $urandom_range(65, 127); cols = $urandom_range(2, 6); end
			4: begin rows = $urandom_range(0, 1) ? 0 : 127; cols = 127; end
			default: begin rows = $urandom_range(2, 8); cols = $urandom_range(2, 8); end
		endcase
		er = rows > 64 ? 64 : rows;
		ec = cols > 64 ? 64 : cols;
		if ($urandom_range(0, 7) == 0)
			write_grid_regs(rows, cols, $urandom_range(0, 63), $urandom_range(0, 63),
			                $urandom_range(0, 63), $urandom_range(0, 63));
		else if ($urandom_range(0, 7) == 0)
			write_grid_regs(rows, cols, 0, 0, 0, 0);
		else
			write_grid_regs(rows, cols, $urandom_range(0, er > 0 ? er - 1 : 0),
			                $urandom_range(0, ec > 0 ? ec - 1 : 0),
			                $urandom_range(0, er > 0 ? er - 1 : 0),
			                $urandom_range(0, ec > 0 ? ec - 1 : 0));
		span = er * ec;
		if ($urandom_range(0, 3) == 0) push_op(CMD_STEP, 0, 0);
		for (int i = 0; i < (span > 40 ? 20 : span / 3 + 2); i++) begin
			if ($urandom_range(0, 9) == 0)
				push_op(cmd_t'($urandom_range(0, 2)), $urandom_range(0, 63),
				        $urandom_range(0, 63));
			else
				push_op(cmd_t'($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0),
				        $urandom_range(0, er), $urandom_range(0, ec));
		end
		push_op(CMD_START, $urandom_range(0, 63), $urandom_range(0, 63));
		nsteps = span > 64 ? 30 : span + 3;
		for (int i = 0; i < nsteps; i++) begin
			if ($urandom_range(0, 15) == 0) push_op(CMD_READ, $urandom_range(0, er),
			                                        $urandom_range(0, ec));
			push_op(CMD_STEP, $urandom_range(0, 63), $urandom_range(0, 63));
		end
		for (int i = 0; i < 10; i++)
			push_op(CMD_READ, $urandom_range(0, er), $urandom_range(0, ec));
		if ($urandom_range(0, 1)) push_op(CMD_NOP, $urandom_range(0, 63), $urandom_range(0, 63));
		if ($urandom_range(0, 2) == 0) begin
			push_op(CMD_CLEAR, 0, 0);
			push_op(CMD_READ, $urandom_range(0, er), $urandom_range(0, ec));
		end
		wait_idle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// Default settings: start, end, edits on them, idle step, no-op, clear.
		push_op(CMD_READ, 5, 5);
		push_op(CMD_READ, 24, 34);
		push_op(CMD_SET, 5, 5);
		push_op(CMD_TOGGLE, 24, 34);
		push_op(CMD_READ, 5, 5);
		push_op(CMD_SET, 63, 63);
		push_op(CMD_READ, 63, 63);
		push_op(CMD_TOGGLE, 63, 63);
		push_op(CMD_TOGGLE, 0, 0);
		push_op(CMD_ERASE, 0, 0);
		push_op(CMD_READ, 0, 0);
		push_op(CMD_NOP, 63, 0);
		push_op(CMD_STEP, 0, 0);
		push_op(CMD_STEP, 0, 0);
		push_op(CMD_CLEAR, 0, 63);
		wait_idle();

		// Small grid, out of bounds edits and reads, start equal to end.
		write_grid_regs(2, 3, 1, 2, 1, 2);
		push_op(CMD_SET, 2, 0);
		push_op(CMD_READ, 0, 3);
		push_op(CMD_READ, 1, 2);
		push_op(CMD_START, 0, 0);
		push_op(CMD_STEP, 0, 0);
		push_op(CMD_STEP, 0, 0);
		push_op(CMD_READ, 0, 0);
		wait_idle();

		while (op_count < 420) begin
			if (op_count > 340) calm = 1;
			random_phase();
		end
		wait_idle();
		repeat (50) @(posedge clk);
		if (sb.fails == 0 && sb.pending_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
